>>> sv/skt_pkg.sv
// Shared types, codes and default sizes for the sorted key table.
`timescale 1ns / 1ps

package skt_pkg;

    localparam int DEF_DEPTH     = 64;
    localparam int DEF_KEY_WIDTH = 32;
    localparam int ACT_W         = 3;
    localparam int STATUS_W      = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 3'd0,
        ACT_SEARCH = 3'd1,
        ACT_DELETE = 3'd2,
        ACT_MIN    = 3'd3,
        ACT_MAX    = 3'd4,
        ACT_PRED   = 3'd5,
        ACT_SUCC   = 3'd6
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // Starting index loaded with a new transaction
    typedef enum logic [2:0] {
        ISEL_ZERO = 3'd0,
        ISEL_CNT  = 3'd1,
        ISEL_LAST = 3'd2,
        ISEL_POS  = 3'd3,
        ISEL_PRED = 3'd4,
        ISEL_SUCC = 3'd5
    } t_isel;

    // Read address offset from the current index
    typedef enum logic [1:0] {
        OFS_ZERO = 2'd0,
        OFS_DEC  = 2'd1,
        OFS_INC  = 2'd2
    } t_ofs;

    typedef enum logic [1:0] {
        KSEL_RD   = 2'd0,
        KSEL_KEY  = 2'd1,
        KSEL_HOLD = 2'd2
    } t_ksel;

    typedef enum logic {
        PSEL_IDX = 1'b0,
        PSEL_POS = 1'b1
    } t_psel;

    typedef struct packed {
        logic    load;
        t_isel   isel;
        logic    rd_en;
        t_ofs    rd_ofs;
        logic    wr_en;
        logic    wr_key;
        logic    idx_inc;
        logic    idx_dec;
        logic    save_key;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    done;
        t_status status;
        t_ksel   ksel;
        t_psel   psel;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_ok;
        logic pred_ok;
        logic succ_ok;
        logic gt;
        logic eq;
        logic idx_zero;
        logic idx_last;
    } t_stat;

endpackage

>>> sv/skt_dpath.sv
// Datapath of the sorted key table: key memory, index, count and result registers.
`timescale 1ns / 1ps

module skt_dpath #(
    parameter int DEPTH     = skt_pkg::DEF_DEPTH,
    parameter int KEY_WIDTH = skt_pkg::DEF_KEY_WIDTH,
    localparam int IDX_W    = $clog2(DEPTH),
    localparam int CNT_W    = $clog2(DEPTH + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  skt_pkg::t_cmd               i_cmd,
    output skt_pkg::t_stat              o_stat,
    input  logic signed [KEY_WIDTH-1:0] i_key,
    input  logic        [IDX_W-1:0]     i_position,
    output logic                        o_strobe,
    output skt_pkg::t_status            o_status,
    output logic signed [KEY_WIDTH-1:0] o_found_key,
    output logic        [IDX_W-1:0]     o_found_position,
    output logic        [CNT_W-1:0]     o_entry_count
);

    logic signed [KEY_WIDTH-1:0] r_mem [DEPTH];
    logic signed [KEY_WIDTH-1:0] r_rd_data;
    logic signed [KEY_WIDTH-1:0] r_key;
    logic        [IDX_W-1:0]     r_pos;
    logic        [IDX_W-1:0]     r_idx;
    logic        [CNT_W-1:0]     r_cnt;
    logic                        r_strobe;
    skt_pkg::t_status            r_status;
    logic signed [KEY_WIDTH-1:0] r_fkey;
    logic        [IDX_W-1:0]     r_fpos;

    logic        [IDX_W-1:0]     w_rd_addr;
    logic signed [KEY_WIDTH-1:0] w_wr_data;
    logic        [IDX_W-1:0]     n_idx;
    logic        [CNT_W:0]       w_pos_next;

    always_comb begin
        case (i_cmd.rd_ofs)
            skt_pkg::OFS_DEC: w_rd_addr = r_idx - IDX_W'(1);
            skt_pkg::OFS_INC: w_rd_addr = r_idx + IDX_W'(1);
            default:          w_rd_addr = r_idx;
        endcase
    end

    assign w_wr_data  = i_cmd.wr_key ? r_key : r_rd_data;
    assign w_pos_next = (CNT_W + 1)'(i_position) + (CNT_W + 1)'(1);

    always_comb begin
        o_stat.full     = (r_cnt == CNT_W'(DEPTH));
        o_stat.empty    = (r_cnt == '0);
        o_stat.pos_ok   = (CNT_W'(i_position) < r_cnt);
        o_stat.pred_ok  = (CNT_W'(i_position) < r_cnt) && (i_position != '0);
        o_stat.succ_ok  = (w_pos_next < (CNT_W + 1)'(r_cnt));
        o_stat.gt       = (r_rd_data > r_key);
        o_stat.eq       = (r_rd_data == r_key);
        o_stat.idx_zero = (r_idx == '0);
        o_stat.idx_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_cnt);
    end

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.load) begin
            case (i_cmd.isel)
                skt_pkg::ISEL_CNT:  n_idx = r_cnt[IDX_W-1:0];
                skt_pkg::ISEL_LAST: n_idx = IDX_W'(r_cnt - CNT_W'(1));
                skt_pkg::ISEL_POS:  n_idx = i_position;
                skt_pkg::ISEL_PRED: n_idx = i_position - IDX_W'(1);
                skt_pkg::ISEL_SUCC: n_idx = i_position + IDX_W'(1);
                default:            n_idx = '0;
            endcase
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + IDX_W'(1);
        end else if (i_cmd.idx_dec) begin
            n_idx = r_idx - IDX_W'(1);
        end
    end

    // Key memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[r_idx] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load) begin
            r_key <= i_key;
            r_pos <= i_position;
        end
        if (i_cmd.save_key) begin
            r_fkey <= r_rd_data;
        end
        if (i_cmd.done) begin
            r_status <= i_cmd.status;
            if (i_cmd.status != skt_pkg::ST_OK) begin
                r_fkey <= '0;
                r_fpos <= '0;
            end else begin
                case (i_cmd.ksel)
                    skt_pkg::KSEL_RD:  r_fkey <= r_rd_data;
                    skt_pkg::KSEL_KEY: r_fkey <= r_key;
                    default:           r_fkey <= r_fkey;
                endcase
                r_fpos <= (i_cmd.psel == skt_pkg::PSEL_POS) ? r_pos : r_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.done;
            if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_cmd.cnt_dec) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    assign o_strobe         = r_strobe;
    assign o_status         = r_status;
    assign o_found_key      = r_fkey;
    assign o_found_position = r_fpos;
    assign o_entry_count    = r_cnt;

`ifndef SYNTHESIS
    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |-> (CNT_W'(r_idx) <= r_cnt))
        else $error("key write beyond the filled region");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_inc |=> (r_cnt <= CNT_W'(DEPTH)) && (r_cnt != '0))
        else $error("entry count outside table depth");
`endif

endmodule

>>> sv/skt_ctrl.sv
// Controller state machine of the sorted key table.
`timescale 1ns / 1ps

module skt_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [skt_pkg::ACT_W-1:0]   i_action,
    input  skt_pkg::t_stat              i_stat,
    output skt_pkg::t_cmd               o_cmd,
    output logic                        o_busy
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_READ     = 5'b00010,
        S_EVAL     = 5'b00100,
        S_SHIFT_RD = 5'b01000,
        S_SHIFT_WR = 5'b10000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    skt_pkg::t_action r_op;
    skt_pkg::t_action n_op;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;

        o_cmd.load     = 1'b0;
        o_cmd.isel     = skt_pkg::ISEL_ZERO;
        o_cmd.rd_en    = 1'b0;
        o_cmd.rd_ofs   = skt_pkg::OFS_ZERO;
        o_cmd.wr_en    = 1'b0;
        o_cmd.wr_key   = 1'b0;
        o_cmd.idx_inc  = 1'b0;
        o_cmd.idx_dec  = 1'b0;
        o_cmd.save_key = 1'b0;
        o_cmd.cnt_inc  = 1'b0;
        o_cmd.cnt_dec  = 1'b0;
        o_cmd.done     = 1'b0;
        o_cmd.status   = skt_pkg::ST_OK;
        o_cmd.ksel     = skt_pkg::KSEL_RD;
        o_cmd.psel     = skt_pkg::PSEL_IDX;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op = skt_pkg::t_action'(i_action);
                    // assume a reject; valid cases below override
                    o_cmd.done   = 1'b1;
                    o_cmd.status = skt_pkg::ST_MISS;
                    case (skt_pkg::t_action'(i_action))
                        skt_pkg::ACT_INSERT: begin
                            if (i_stat.full) begin
                                o_cmd.status = skt_pkg::ST_FULL;
                            end else begin
                                o_cmd.done = 1'b0;
                                o_cmd.load = 1'b1;
                                o_cmd.isel = skt_pkg::ISEL_CNT;
                            end
                        end
                        skt_pkg::ACT_SEARCH, skt_pkg::ACT_MIN: begin
                            if (!i_stat.empty) begin
                                o_cmd.done = 1'b0;
                                o_cmd.load = 1'b1;
                                o_cmd.isel = skt_pkg::ISEL_ZERO;
                            end
                        end
                        skt_pkg::ACT_MAX: begin
                            if (!i_stat.empty) begin
                                o_cmd.done = 1'b0;
                                o_cmd.load = 1'b1;
                                o_cmd.isel = skt_pkg::ISEL_LAST;
                            end
                        end
                        skt_pkg::ACT_DELETE: begin
                            if (i_stat.pos_ok) begin
                                o_cmd.done = 1'b0;
                                o_cmd.load = 1'b1;
                                o_cmd.isel = skt_pkg::ISEL_POS;
                            end
                        end
                        skt_pkg::ACT_PRED: begin
                            if (i_stat.pred_ok) begin
                                o_cmd.done = 1'b0;
                                o_cmd.load = 1'b1;
                                o_cmd.isel = skt_pkg::ISEL_PRED;
                            end
                        end
                        skt_pkg::ACT_SUCC: begin
                            if (i_stat.succ_ok) begin
                                o_cmd.done = 1'b0;
                                o_cmd.load = 1'b1;
                                o_cmd.isel = skt_pkg::ISEL_SUCC;
                            end
                        end
                        default: begin
                            o_cmd.status = skt_pkg::ST_MISS;
                        end
                    endcase
                    if (o_cmd.load) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                if (r_op == skt_pkg::ACT_INSERT && i_stat.idx_zero) begin
                    // reached the bottom slot: drop the key in
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_key  = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    o_cmd.done    = 1'b1;
                    o_cmd.ksel    = skt_pkg::KSEL_KEY;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_ofs = (r_op == skt_pkg::ACT_INSERT) ? skt_pkg::OFS_DEC
                                                                 : skt_pkg::OFS_ZERO;
                    n_state      = S_EVAL;
                end
            end
            S_EVAL: begin
                case (r_op)
                    skt_pkg::ACT_INSERT: begin
                        if (i_stat.gt) begin
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.idx_dec = 1'b1;
                            n_state       = S_READ;
                        end else begin
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.wr_key  = 1'b1;
                            o_cmd.cnt_inc = 1'b1;
                            o_cmd.done    = 1'b1;
                            o_cmd.ksel    = skt_pkg::KSEL_KEY;
                            n_state       = S_IDLE;
                        end
                    end
                    skt_pkg::ACT_SEARCH: begin
                        if (i_stat.eq) begin
                            o_cmd.done = 1'b1;
                            o_cmd.ksel = skt_pkg::KSEL_KEY;
                            n_state    = S_IDLE;
                        end else if (i_stat.gt || i_stat.idx_last) begin
                            o_cmd.done   = 1'b1;
                            o_cmd.status = skt_pkg::ST_MISS;
                            n_state      = S_IDLE;
                        end else begin
                            o_cmd.idx_inc = 1'b1;
                            n_state       = S_READ;
                        end
                    end
                    skt_pkg::ACT_DELETE: begin
                        o_cmd.save_key = 1'b1;
                        n_state        = S_SHIFT_RD;
                    end
                    default: begin
                        o_cmd.done = 1'b1;
                        n_state    = S_IDLE;
                    end
                endcase
            end
            S_SHIFT_RD: begin
                if (i_stat.idx_last) begin
                    o_cmd.cnt_dec = 1'b1;
                    o_cmd.done    = 1'b1;
                    o_cmd.ksel    = skt_pkg::KSEL_HOLD;
                    o_cmd.psel    = skt_pkg::PSEL_POS;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_ofs = skt_pkg::OFS_INC;
                    n_state      = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state       = S_SHIFT_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= skt_pkg::ACT_INSERT;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    assign o_busy = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.done |=> (r_state == S_IDLE))
        else $error("controller still busy after finishing a transaction");

    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (r_state == S_IDLE) && i_start && !o_cmd.done)
        else $error("transaction loaded outside an accept");

    a_write_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_en |=> !o_cmd.wr_en || (r_op == skt_pkg::ACT_INSERT && o_cmd.done))
        else $error("back-to-back key writes inside one transaction");
`endif

endmodule

>>> sv/sorted_key_table.sv
// Top level of the sorted key table: controller plus datapath.
`timescale 1ns / 1ps

// Sorted key table: holds up to DEPTH signed keys in ascending order,
// duplicates allowed (a new key goes after any equal keys).
// Request channel: drive i_action, i_key and i_position with start high;
// the transaction is taken at the clock edge where start is high and busy
// is low. busy stays high until the transaction has finished.
// Result channel: o_status, o_found_key, o_found_position and
// o_entry_count are valid for the single cycle in which o_strobe is high.
// The receiver cannot stall; results not taken in that cycle are lost.
// Work done from accept to strobe, with n keys held:
//   rejected request (full, empty, bad position, unknown action): answered
//     from idle, busy never goes high; min, max, predecessor, successor: one read
//   search hitting or passing sorted position p: scans entries 0 to p
//   insert landing at position p: moves entries p to n-1 up by one
//   delete at position p: moves entries p+1 to n-1 down by one
// Each step is one registered read of the key memory followed by a compare,
// a write or both, one step per entry scanned or moved.
// Reset clears the entry count, the strobe and the controller state; the key
// memory and result registers are left as is, and only entries below the count are ever read.
module sorted_key_table #(
    parameter int DEPTH     = skt_pkg::DEF_DEPTH,
    parameter int KEY_WIDTH = skt_pkg::DEF_KEY_WIDTH,
    localparam int IDX_W    = $clog2(DEPTH),
    localparam int CNT_W    = $clog2(DEPTH + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [skt_pkg::ACT_W-1:0]      i_action,
    input  logic signed [KEY_WIDTH-1:0]    i_key,
    input  logic [IDX_W-1:0]               i_position,
    output logic                           o_strobe,
    output logic [skt_pkg::STATUS_W-1:0]   o_status,
    output logic signed [KEY_WIDTH-1:0]    o_found_key,
    output logic [IDX_W-1:0]               o_found_position,
    output logic [CNT_W-1:0]               o_entry_count
);

    skt_pkg::t_cmd    w_cmd;
    skt_pkg::t_stat   w_stat;
    skt_pkg::t_status w_status;
    logic             w_busy;

    // Controller: sequences each transaction through read / compare / write
    skt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_busy   (w_busy)
    );

    // Datapath: key memory, walking index, entry count and result registers
    skt_dpath #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_key            (i_key),
        .i_position       (i_position),
        .o_strobe         (o_strobe),
        .o_status         (w_status),
        .o_found_key      (o_found_key),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count)
    );

    assign busy     = w_busy;
    assign o_status = w_status;

endmodule

>>> bench/sorted_key_table_test.sv
// Self-checking testbench for the sorted key table: directed and random operations.
`timescale 1ns / 1ps

module sorted_key_table_test;
    import skt_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 1_000_000;
    // Quiet tail after the last reply; gives the longest scan of a full table room.
    localparam int DRAIN_CYCLES = 300;
    localparam int RANDOM_PER_PHASE = 375;
    localparam int MAX_REPORTS = 100;

    // Action code outside the defined set: the table must report a miss.
    localparam logic [ACT_W-1:0] ACT_UNDEFINED = 3'd7;

    localparam logic signed [31:0] KEY_LOWEST  = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_HIGHEST = 32'sh7fff_ffff;

    // One operation request as it goes onto the request ports, plus the
    // chance (in percent) that the driver idles in any free cycle before it.
    typedef struct {
        logic [ACT_W-1:0]  action;
        logic signed [31:0] key;
        logic [5:0]        position;
        int                gap_pct;
    } table_op_t;

    // One reply as it comes off the result ports.
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic signed [31:0]  key;
        logic [5:0]          position;
        logic [6:0]          count;
    } table_reply_t;

    // Random segments lean toward filling, draining or neither.
    typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [ACT_W-1:0]          i_action;
    logic signed [31:0]        i_key;
    logic [5:0]                i_position;
    logic                      o_strobe;
    logic [STATUS_W-1:0]       o_status;
    logic signed [31:0]        o_found_key;
    logic [5:0]                o_found_position;
    logic [6:0]                o_entry_count;

    // Stimulus and scoreboard storage
    table_op_t                 pending_ops[$];
    table_reply_t              pending_replies[$];
    logic signed [31:0]        key_pool[$];

    // Shadow of the table contents, advanced once per accepted transaction
    logic signed [31:0]        model_keys [TABLE_DEPTH];
    int                        model_count;

    // Entry count as the stimulus generator sees it, used to aim positions
    int                        gen_count;

    int                        sent_count;
    int                        accepted_count;
    int                        total_ops;
    int                        error_count;
    int                        cycle_count;

    sorted_key_table u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_key            (i_key),
        .i_position       (i_position),
        .o_strobe         (o_strobe),
        .o_status         (o_status),
        .o_found_key      (o_found_key),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction: apply one operation to the shadow table and return the
    // reply the block must give. Keys compare as signed values; a new key
    // lands after any equal keys, and a search reports the first match.
    // ------------------------------------------------------------------
    function automatic table_reply_t predict_reply(logic [ACT_W-1:0] act,
                                                   logic signed [31:0] k,
                                                   logic [5:0] p);
        table_reply_t r;
        logic signed [31:0] gone;
        int i;
        r.status   = ST_MISS;
        r.key      = '0;
        r.position = '0;
        case (act)
            ACT_INSERT: begin
                if (model_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    i = 0;
                    while (i < model_count && model_keys[i] <= k)
                        i++;
                    for (int j = model_count; j > i; j--)
                        model_keys[j] = model_keys[j-1];
                    model_keys[i] = k;
                    model_count++;
                    r.status   = ST_OK;
                    r.key      = k;
                    r.position = i[5:0];
                end
            end
            ACT_SEARCH: begin
                for (i = 0; i < model_count; i++) begin
                    if (model_keys[i] == k) begin
                        r.status   = ST_OK;
                        r.key      = k;
                        r.position = i[5:0];
                        break;
                    end
                    // Passed the spot where the key would sit: give up
                    if (model_keys[i] > k)
                        break;
                end
            end
            ACT_DELETE: begin
                if (p < model_count) begin
                    gone = model_keys[p];
                    for (i = p; i + 1 < model_count; i++)
                        model_keys[i] = model_keys[i+1];
                    model_count--;
                    r.status   = ST_OK;
                    r.key      = gone;
                    r.position = p;
                end
            end
            ACT_MIN: begin
                if (model_count > 0) begin
                    r.status = ST_OK;
                    r.key    = model_keys[0];
                end
            end
            ACT_MAX: begin
                if (model_count > 0) begin
                    i = model_count - 1;
                    r.status   = ST_OK;
                    r.key      = model_keys[i];
                    r.position = i[5:0];
                end
            end
            ACT_PRED: begin
                if (p < model_count && p > 0) begin
                    r.status   = ST_OK;
                    r.key      = model_keys[p-1];
                    r.position = p - 6'd1;
                end
            end
            ACT_SUCC: begin
                if (p + 1 < model_count) begin
                    r.status   = ST_OK;
                    r.key      = model_keys[p+1];
                    r.position = p + 6'd1;
                end
            end
            default: begin
            end
        endcase
        r.count = model_count[6:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Queue one operation and track the count and the keys put in, so that
    // positions and search keys can be aimed at live entries.
    task automatic queue_op(logic [ACT_W-1:0] act, logic signed [31:0] k,
                            logic [5:0] p, int gap);
        table_op_t op;
        op.action   = act;
        op.key      = k;
        op.position = p;
        op.gap_pct  = gap;
        pending_ops.push_back(op);
        if (act == ACT_INSERT && gen_count < TABLE_DEPTH) begin
            gen_count++;
            key_pool.push_back(k);
            if (key_pool.size() > TABLE_DEPTH)
                void'(key_pool.pop_front());
        end
        if (act == ACT_DELETE && p < gen_count)
            gen_count--;
    endtask

    // Mix of wide random keys, a narrow band that makes duplicates, the
    // extremes of the signed range, and keys already put in.
    function automatic logic signed [31:0] pick_key();
        int r;
        r = $urandom_range(9);
        if (r < 4)
            return $urandom;
        if (r < 7)
            return $signed($urandom_range(16)) - 32'sd8;
        if (r == 7) begin
            case ($urandom_range(3))
                0:       return KEY_LOWEST;
                1:       return KEY_HIGHEST;
                2:       return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        if (key_pool.size() > 0)
            return key_pool[$urandom_range(key_pool.size() - 1)];
        return $urandom;
    endfunction

    // Mostly live positions, with the first and last entries and the whole
    // six-bit range mixed in.
    function automatic logic [5:0] pick_position();
        int r;
        r = $urandom_range(9);
        if (gen_count > 0 && r < 6)
            return 6'($urandom_range(gen_count - 1));
        if (gen_count > 0 && r == 6)
            return 6'(gen_count - 1);
        if (r == 7)
            return 6'd0;
        return 6'($urandom_range(63));
    endfunction

    // ------------------------------------------------------------------
    // Driver: present a new transaction at the falling edge whenever the
    // request slot is free, idling at random as the next item asks. Hold
    // the request steady while the block is busy.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        table_op_t op;
        if (i_rst_n && (!start || accepted_count == sent_count)) begin
            if (pending_ops.size() != 0 &&
                $urandom_range(99) >= pending_ops[0].gap_pct) begin
                op = pending_ops.pop_front();
                i_action   <= op.action;
                i_key      <= op.key;
                i_position <= op.position;
                start      <= 1'b1;
                sent_count++;
            end else begin
                // Drop start and scramble the request fields while idle
                i_action   <= 3'($urandom_range(7));
                i_key      <= $urandom;
                i_position <= 6'($urandom_range(63));
                start      <= 1'b0;
            end
        end
    end

    task automatic compare_reply_field(string what, logic signed [32:0] want,
                                       logic signed [32:0] got);
        if (got !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, what, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: at each rising edge, check a strobed reply against the
    // oldest prediction, then predict for a transaction taken at this edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        table_reply_t want;
        if (i_rst_n && o_strobe) begin
            if (pending_replies.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: reply with none expected: status %0d key %0d pos %0d",
                             $time, o_status, o_found_key, o_found_position);
            end else begin
                want = pending_replies.pop_front();
                compare_reply_field("status", want.status, o_status);
                compare_reply_field("found_key", want.key, o_found_key);
                compare_reply_field("found_position", want.position, o_found_position);
                compare_reply_field("entry_count", want.count, o_entry_count);
            end
        end
        if (i_rst_n && start && !busy) begin
            pending_replies.push_back(predict_reply(i_action, i_key, i_position));
            accepted_count++;
        end
    end

    // Hard stop in case the block hangs or drops a reply
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: build the whole item list, release reset, then wait for
    // every reply and a quiet tail before the verdict.
    // ------------------------------------------------------------------
    initial begin
        int gaps [4];
        mix_t mix;
        int seg_left;
        int ins_lim;
        int del_lim;
        int r;
        logic [ACT_W-1:0] act;

        start          = 1'b0;
        i_action       = ACT_INSERT;
        i_key          = '0;
        i_position     = '0;
        i_rst_n        = 1'b0;
        model_count    = 0;
        gen_count      = 0;
        sent_count     = 0;
        accepted_count = 0;
        error_count    = 0;
        cycle_count    = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            model_keys[i] = '0;

        // Empty table: every lookup and delete misses, unknown action too
        queue_op(ACT_MIN,       32'sd0, 6'd0, 0);
        queue_op(ACT_MAX,       32'sd0, 6'd0, 0);
        queue_op(ACT_SEARCH,    32'sd0, 6'd0, 0);
        queue_op(ACT_DELETE,    32'sd0, 6'd0, 0);
        queue_op(ACT_PRED,      32'sd0, 6'd0, 0);
        queue_op(ACT_SUCC,      32'sd0, 6'd0, 0);
        queue_op(ACT_UNDEFINED, 32'sd0, 6'd0, 0);
        // Extremes and duplicates; the lowest key lands at the front
        queue_op(ACT_INSERT, 32'sd0,      6'd0, 0);
        queue_op(ACT_INSERT, KEY_HIGHEST, 6'd0, 0);
        queue_op(ACT_INSERT, KEY_LOWEST,  6'd0, 0);
        queue_op(ACT_INSERT, -32'sd1,     6'd0, 0);
        queue_op(ACT_INSERT, 32'sd0,      6'd0, 0);
        queue_op(ACT_INSERT, KEY_HIGHEST, 6'd0, 0);
        // First occurrence of a duplicate, a miss between keys, the top key
        queue_op(ACT_SEARCH, 32'sd0,      6'd0, 0);
        queue_op(ACT_SEARCH, 32'sd5,      6'd0, 0);
        queue_op(ACT_SEARCH, KEY_HIGHEST, 6'd0, 0);
        queue_op(ACT_MIN,    32'sd0,      6'd0, 0);
        queue_op(ACT_MAX,    32'sd0,      6'd0, 0);
        // Neighbors at both ends and inside
        queue_op(ACT_PRED,   32'sd0,      6'd0, 0);
        queue_op(ACT_PRED,   32'sd0,      6'd5, 0);
        queue_op(ACT_SUCC,   32'sd0,      6'd5, 0);
        queue_op(ACT_SUCC,   32'sd0,      6'd0, 0);
        // Position past the count, then a good delete
        queue_op(ACT_DELETE, 32'sd0,      6'd63, 0);
        queue_op(ACT_DELETE, 32'sd0,      6'd2, 0);
        queue_op(ACT_PRED,   32'sd0,      6'd63, 0);

        // Random phases: no idling, heavy idling, no idling, light idling
        gaps = '{0, 81, 0, 34};
        mix = MIX_FILL;
        seg_left = 0;
        for (int ph = 0; ph < 4; ph++) begin
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(200, 60);
                    case ($urandom_range(2))
                        0:       mix = MIX_FILL;
                        1:       mix = MIX_DRAIN;
                        default: mix = MIX_EVEN;
                    endcase
                end
                seg_left--;
                case (mix)
                    MIX_FILL:  begin ins_lim = 65; del_lim = 72; end
                    MIX_DRAIN: begin ins_lim = 12; del_lim = 70; end
                    default:   begin ins_lim = 35; del_lim = 55; end
                endcase
                r = $urandom_range(99);
                if (r < ins_lim) begin
                    act = ACT_INSERT;
                end else if (r < del_lim) begin
                    act = ACT_DELETE;
                end else begin
                    r = $urandom_range(99);
                    if (r < 40)      act = ACT_SEARCH;
                    else if (r < 52) act = ACT_MIN;
                    else if (r < 64) act = ACT_MAX;
                    else if (r < 80) act = ACT_PRED;
                    else if (r < 97) act = ACT_SUCC;
                    else             act = ACT_UNDEFINED;
                end
                // Aim searches at keys already put in more often than not
                if (act == ACT_SEARCH && key_pool.size() > 0 && $urandom_range(9) < 6)
                    queue_op(act, key_pool[$urandom_range(key_pool.size() - 1)],
                             pick_position(), gaps[ph]);
                else
                    queue_op(act, pick_key(), pick_position(), gaps[ph]);
            end
        end
        total_ops = pending_ops.size();

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every transaction to be taken and every reply checked
        while (accepted_count < total_ops || pending_replies.size() != 0)
            @(negedge i_clk);
        // Hold a little longer to catch a stray reply
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
